### src/glcm_pkg.sv
// Shared constants, types and helpers for the co-occurrence matrix accumulator.
// Used by glcm_front, glcm_queue, glcm_back and the top level. No dependencies.
`default_nettype none
package glcm_pkg;

    // Sizing
    localparam int LEVELS     = 256;
    localparam int MAX_WIDTH  = 2048;
    localparam int COUNT_BITS = 32;

    localparam int LVL_BITS   = $clog2(LEVELS);
    localparam int TBL_DEPTH  = LEVELS * LEVELS;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int PIX_BITS   = 8;
    localparam int WID_BITS   = 12;
    localparam int DIR_BITS   = 2;
    localparam int FUNC_BITS  = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = WID_BITS;

    localparam logic [WID_BITS-1:0]   LINE_WIDTH_RESET = WID_BITS'(640);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Input word function codes
    localparam logic [FUNC_BITS-1:0] FUNC_PIXEL = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    // Direction codes
    localparam logic [DIR_BITS-1:0] DIR_0   = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_90  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_45  = 2'd2;
    localparam logic [DIR_BITS-1:0] DIR_135 = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 1'd1;

    // Back-end command kinds
    localparam logic [1:0] CMD_PAIR  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]        kind;
        logic              oob;   // read outside the table
        logic [TBL_AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    // Gray level clamped into the table
    function automatic logic [LVL_BITS-1:0] to_level(input logic [PIX_BITS-1:0] v);
        if (32'(v) >= LEVELS) begin
            return LVL_BITS'(LEVELS - 1);
        end
        return v[LVL_BITS-1:0];
    endfunction

    // Table address of (reference, neighbour)
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_BITS-1:0] r,
                                                   input logic [LVL_BITS-1:0] n);
        return TBL_AW'(32'(r) * LEVELS + 32'(n));
    endfunction

endpackage
`default_nettype wire

### src/glcm_front.sv
// Front end: configuration registers, line store and neighbour selection.
// Turns each accepted word into a table command. Depends on glcm_pkg.
`default_nettype none
module glcm_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire glcm_pkg::t_cfg_wr           i_cfg,
    input  wire glcm_pkg::t_back_status      i_status,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [glcm_pkg::FUNC_BITS-1:0] i_func,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]  i_pixel,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]  i_ref_level,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]  i_nbr_level,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_ready,
    output glcm_pkg::t_cmd                   o_cmd
);
    import glcm_pkg::*;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_WORK = 1'b1;

    logic                 r_state, n_state;
    logic [DIR_BITS-1:0]  r_direction;
    logic [WID_BITS-1:0]  r_line_width;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic                 r_first, n_first;
    logic [PIX_BITS-1:0]  r_left, n_left;
    logic [PIX_BITS-1:0]  r_diag, n_diag;

    // Held word
    logic [FUNC_BITS-1:0] r_func;
    logic [PIX_BITS-1:0]  r_pixel;
    logic [PIX_BITS-1:0]  r_ref;
    logic [PIX_BITS-1:0]  r_nbr;
    logic [PIX_BITS-1:0]  r_above;
    logic [PIX_BITS-1:0]  r_above_right;

    logic [PIX_BITS-1:0]  line_mem [MAX_WIDTH];

    logic                 accept;
    logic [COL_BITS-1:0]  col_right;
    logic [WID_BITS-1:0]  w_eff;
    logic [COL_BITS:0]    c1;
    logic                 pair_ok;
    logic [PIX_BITS-1:0]  pair_ref;
    logic                 need_push;
    logic                 done;
    logic                 line_we;

    assign o_ready   = (r_state == F_IDLE) && !i_status.clearing;
    assign accept    = i_valid && o_ready;
    assign col_right = r_col + 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_0;
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                REG_DIRECTION:  r_direction  <= i_cfg.data[DIR_BITS-1:0];
                REG_LINE_WIDTH: r_line_width <= i_cfg.data[WID_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Line store: both upper neighbours read as the word is taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above       <= line_mem[r_col];
            r_above_right <= line_mem[col_right];
        end
        if (line_we) begin
            line_mem[r_col] <= r_pixel;
        end
    end

    // Held word, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_pixel <= i_pixel;
            r_ref   <= i_ref_level;
            r_nbr   <= i_nbr_level;
        end
    end

    // Effective row width and pair selection
    always_comb begin
        w_eff = r_line_width;
        if (r_line_width < WID_BITS'(2)) begin
            w_eff = WID_BITS'(2);
        end else if (r_line_width > WID_BITS'(MAX_WIDTH)) begin
            w_eff = WID_BITS'(MAX_WIDTH);
        end
        c1 = {1'b0, r_col} + 1'b1;

        pair_ok  = 1'b0;
        pair_ref = r_left;
        unique case (r_direction)
            DIR_0: begin
                pair_ok  = (r_col != '0);
                pair_ref = r_left;
            end
            DIR_90: begin
                pair_ok  = !r_first;
                pair_ref = r_above;
            end
            DIR_45: begin
                pair_ok  = !r_first && (r_col != '0);
                pair_ref = r_diag;
            end
            DIR_135: begin
                pair_ok  = !r_first && (WID_BITS'(c1) < w_eff)
                           && (32'(c1) < MAX_WIDTH);
                pair_ref = r_above_right;
            end
            default: ;
        endcase
    end

    // Command build and state update
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_first   = r_first;
        n_left    = r_left;
        n_diag    = r_diag;
        need_push = 1'b0;
        line_we   = 1'b0;
        o_cmd     = '0;

        unique case (r_func)
            FUNC_PIXEL: begin
                need_push  = pair_ok;
                o_cmd.kind = CMD_PAIR;
                o_cmd.addr = tbl_addr(to_level(pair_ref), to_level(r_pixel));
            end
            FUNC_READ: begin
                need_push  = 1'b1;
                o_cmd.kind = CMD_READ;
                o_cmd.oob  = (32'(r_ref) >= LEVELS) || (32'(r_nbr) >= LEVELS);
                o_cmd.addr = tbl_addr(r_ref[LVL_BITS-1:0], r_nbr[LVL_BITS-1:0]);
            end
            FUNC_CLEAR: begin
                need_push  = 1'b1;
                o_cmd.kind = CMD_CLEAR;
            end
            default: ;
        endcase

        o_cmd_valid = (r_state == F_WORK) && need_push;
        done        = (r_state == F_WORK) && (!need_push || i_cmd_ready);

        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_WORK;
                end
            end
            F_WORK: begin
                if (done) begin
                    n_state = F_IDLE;
                    if (r_func == FUNC_PIXEL) begin
                        line_we = 1'b1;
                        n_diag  = r_above;
                        n_left  = r_pixel;
                        if (WID_BITS'(c1) >= w_eff) begin
                            n_col   = '0;
                            n_first = 1'b0;
                        end else begin
                            n_col = c1[COL_BITS-1:0];
                        end
                    end else if (r_func == FUNC_CLEAR) begin
                        n_col   = '0;
                        n_first = 1'b1;
                        n_left  = '0;
                        n_diag  = '0;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_first <= 1'b1;
            r_left  <= '0;
            r_diag  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_first <= n_first;
            r_left  <= n_left;
            r_diag  <= n_diag;
        end
    end

endmodule
`default_nettype wire

### src/glcm_queue.sv
// Short command queue between the front end and the table back end.
// Depends on glcm_pkg for the command type and depth.
`default_nettype none
module glcm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire glcm_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output glcm_pkg::t_cmd      o_cmd
);
    import glcm_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Storage, payload only
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/glcm_back.sv
// Back end: count table memory, saturating updates, pair total, read result.
// Runs the clearing sweep after reset and on a clear command. Depends on glcm_pkg.
`default_nettype none
module glcm_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    output logic                       o_cmd_ready,
    input  wire glcm_pkg::t_cmd        i_cmd,
    output glcm_pkg::t_back_status     o_status,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [glcm_pkg::COUNT_BITS-1:0] o_entry_count,
    output logic [glcm_pkg::COUNT_BITS-1:0] o_pair_total
);
    import glcm_pkg::*;

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_UPD   = 2'd2;
    localparam logic [1:0] B_RD    = 2'd3;

    logic [COUNT_BITS-1:0] tbl_mem [TBL_DEPTH];

    logic [1:0]            r_state, n_state;
    logic [TBL_AW-1:0]     r_clr_addr, n_clr_addr;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic                  r_out_valid, n_out_valid;
    logic [TBL_AW-1:0]     r_addr;
    logic                  r_oob;
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] r_out_entry;
    logic [COUNT_BITS-1:0] r_out_total;

    logic                  mem_re;
    logic                  mem_we;
    logic [TBL_AW-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  load_out;

    assign o_status.clearing = (r_state == B_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_entry_count = r_out_entry;
    assign o_pair_total  = r_out_total;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd_ready = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        load_out    = 1'b0;

        unique case (r_state)
            B_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == TBL_DEPTH - 1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_PAIR: begin
                            o_cmd_ready = 1'b1;
                            mem_re      = 1'b1;
                            n_state     = B_UPD;
                        end
                        CMD_READ: begin
                            // only once the result register is free
                            if (!r_out_valid) begin
                                o_cmd_ready = 1'b1;
                                mem_re      = 1'b1;
                                n_state     = B_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            o_cmd_ready = 1'b1;
                            n_clr_addr  = '0;
                            n_total     = '0;
                            n_state     = B_CLEAR;
                        end
                        default: o_cmd_ready = 1'b1;
                    endcase
                end
            end
            B_UPD: begin
                mem_we    = 1'b1;
                mem_wdata = (r_rdata == CNT_MAX) ? r_rdata : r_rdata + 1'b1;
                if (r_total != CNT_MAX) begin
                    n_total = r_total + 1'b1;
                end
                n_state = B_IDLE;
            end
            B_RD: begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
                n_state     = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Count table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= tbl_mem[i_cmd.addr];
        end
    end

    // Command payload and result register
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_addr <= i_cmd.addr;
            r_oob  <= i_cmd.oob;
        end
        if (load_out) begin
            r_out_entry <= r_oob ? '0 : r_rdata;
            r_out_total <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### src/glcm_cooccurrence_accumulator.sv
// Top level of the gray-level co-occurrence matrix accumulator.
// Instantiates glcm_front, glcm_queue and glcm_back; depends on glcm_pkg.
//
//  Channel   Direction  Handshake              Fields
//  input     in         i_valid / o_ready      i_func, i_pixel, i_ref_level, i_nbr_level
//  output    out        o_valid / i_ready      o_entry_count, o_pair_total
//  config    in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// The front end takes no new word until the last one's command, if it has one, is queued;
// in the back end a paired pixel reads the count table and writes it back in the update
// state, and a read reaches the output register via the table read and the read state.
// After reset and after each clear word the table is swept one entry a cycle over
// all 65536 entries, with o_ready low; configuration writes are still taken.
// A full queue stalls the front end; a waiting result stalls the next read and every
// command queued behind it.
`default_nettype none
module glcm_cooccurrence_accumulator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [glcm_pkg::FUNC_BITS-1:0]       i_func,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]        i_pixel,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]        i_ref_level,
    input  wire logic [glcm_pkg::PIX_BITS-1:0]        i_nbr_level,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [glcm_pkg::COUNT_BITS-1:0]           o_entry_count,
    output logic [glcm_pkg::COUNT_BITS-1:0]           o_pair_total,
    input  wire logic                                 i_cfg_we,
    input  wire logic [glcm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [glcm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import glcm_pkg::*;

    t_cfg_wr      cfg;
    t_back_status status;
    t_cmd         f_cmd;
    t_cmd         q_cmd;
    logic         f_cmd_valid;
    logic         f_cmd_ready;
    logic         q_cmd_valid;
    logic         q_cmd_ready;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // Word intake and pair selection
    glcm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_status    (status),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_pixel     (i_pixel),
        .i_ref_level (i_ref_level),
        .i_nbr_level (i_nbr_level),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    // Decoupling queue
    glcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_cmd_valid),
        .o_ready (f_cmd_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_cmd_valid),
        .i_ready (q_cmd_ready),
        .o_cmd   (q_cmd)
    );

    // Count table and results
    glcm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_cmd_valid),
        .o_cmd_ready   (q_cmd_ready),
        .i_cmd         (q_cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_count (o_entry_count),
        .o_pair_total  (o_pair_total)
    );

endmodule
`default_nettype wire

### verif/glcm_cooccurrence_accumulator_test.sv
// Self-checking testbench for glcm_cooccurrence_accumulator: directed and random words
// against an in-bench co-occurrence predictor, with random idling on both channels.
// Depends on glcm_pkg and the glcm_cooccurrence_accumulator RTL.
`timescale 1ns / 1ps
module glcm_cooccurrence_accumulator_test;
    import glcm_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [PIX_BITS-1:0]  pixel;
        logic [PIX_BITS-1:0]  ref_level;
        logic [PIX_BITS-1:0]  nbr_level;
    } t_glcm_word;

    typedef struct packed {
        logic [COUNT_BITS-1:0] entry_count;
        logic [COUNT_BITS-1:0] pair_total;
    } t_glcm_read;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [FUNC_BITS-1:0]     i_func;
    logic [PIX_BITS-1:0]      i_pixel;
    logic [PIX_BITS-1:0]      i_ref_level;
    logic [PIX_BITS-1:0]      i_nbr_level;
    logic                     o_valid;
    logic                     i_ready;
    logic [COUNT_BITS-1:0]    o_entry_count;
    logic [COUNT_BITS-1:0]    o_pair_total;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    glcm_cooccurrence_accumulator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_pixel       (i_pixel),
        .i_ref_level   (i_ref_level),
        .i_nbr_level   (i_nbr_level),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_count (o_entry_count),
        .o_pair_total  (o_pair_total),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state: sparse count table (absent entry = zero), line store, scan position
    logic [COUNT_BITS-1:0] cnt_table [int];
    logic [PIX_BITS-1:0]   row_store [MAX_WIDTH];
    int unsigned           scan_col;
    bit                    first_row;
    logic [PIX_BITS-1:0]   left_px;
    logic [PIX_BITS-1:0]   above_left_px;
    logic [COUNT_BITS-1:0] pair_sum;
    logic [DIR_BITS-1:0]   cur_dir;
    logic [WID_BITS-1:0]   cur_width;

    t_glcm_read pending_reads [$];

    // Run bookkeeping
    int  n_errors;
    int  n_pixels;
    int  n_reads;
    int  n_clears;
    int  n_ignored;
    int  n_phases;
    int  cycle_count;
    bit  vld_held;
    bit  tx_burst;
    bit  rx_burst;
    logic [PIX_BITS-1:0] palette [4];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run-away guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reads still pending", cycle_count,
                 pending_reads.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // ---------------- predictor ----------------

    function automatic logic [LVL_BITS-1:0] clamp_level(input logic [PIX_BITS-1:0] v);
        if (int'(v) >= LEVELS) begin
            return LVL_BITS'(LEVELS - 1);
        end
        return v[LVL_BITS-1:0];
    endfunction

    function automatic void bump_pair(input logic [PIX_BITS-1:0] row_lvl,
                                      input logic [PIX_BITS-1:0] col_lvl);
        int key;
        logic [COUNT_BITS-1:0] cur;
        key = int'(clamp_level(row_lvl)) * LEVELS + int'(clamp_level(col_lvl));
        cur = cnt_table.exists(key) ? cnt_table[key] : '0;
        if (cur != CNT_MAX) begin
            cnt_table[key] = cur + 1'b1;
        end
        if (pair_sum != CNT_MAX) begin
            pair_sum = pair_sum + 1'b1;
        end
    endfunction

    function automatic void restart_image();
        cnt_table.delete();
        scan_col = 0;
        first_row = 1'b1;
        left_px = '0;
        above_left_px = '0;
        pair_sum = '0;
    endfunction

    // Applies one accepted word; returns 1 and the read-back when the word is a read
    function automatic bit fold_word(input t_glcm_word w, output t_glcm_read res);
        int unsigned eff_w;
        int unsigned c;
        int key;
        logic [PIX_BITS-1:0] above;
        bit got;
        got = 1'b0;
        res = '0;
        case (w.func)
            FUNC_PIXEL: begin
                eff_w = cur_width;
                if (eff_w < 2) eff_w = 2;
                if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
                c = scan_col;
                if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
                above = row_store[c];
                case (cur_dir)
                    DIR_0: if (c >= 1) bump_pair(left_px, w.pixel);
                    DIR_90: if (!first_row) bump_pair(above, w.pixel);
                    DIR_45: if (!first_row && c >= 1) bump_pair(above_left_px, w.pixel);
                    default: begin
                        if (!first_row && c + 1 < eff_w && c + 1 < MAX_WIDTH) begin
                            bump_pair(row_store[c + 1], w.pixel);
                        end
                    end
                endcase
                row_store[c] = w.pixel;
                above_left_px = above;
                left_px = w.pixel;
                if (c + 1 >= eff_w) begin
                    scan_col = 0;
                    first_row = 1'b0;
                end else begin
                    scan_col = c + 1;
                end
            end
            FUNC_READ: begin
                if (int'(w.ref_level) < LEVELS && int'(w.nbr_level) < LEVELS) begin
                    key = int'(w.ref_level) * LEVELS + int'(w.nbr_level);
                    if (cnt_table.exists(key)) res.entry_count = cnt_table[key];
                end
                res.pair_total = pair_sum;
                got = 1'b1;
            end
            FUNC_CLEAR: restart_image();
            default: ;
        endcase
        return got;
    endfunction

    // ---------------- input side ----------------

    // Lower valid at the acceptance step if nothing follows straight away
    task automatic drop_valid();
        if (vld_held) begin
            i_valid <= 1'b0;
            vld_held = 1'b0;
        end
    endtask

    task automatic send_word(input t_glcm_word w);
        int gap;
        bit rdy;
        t_glcm_read want;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= w.func;
        i_pixel     <= w.pixel;
        i_ref_level <= w.ref_level;
        i_nbr_level <= w.nbr_level;
        vld_held = 1'b1;
        do begin
            @(negedge i_clk);
            rdy = (o_ready === 1'b1);
            @(posedge i_clk);
        end while (!rdy);
        if (fold_word(w, want)) begin
            pending_reads.push_back(want);
        end
        case (w.func)
            FUNC_PIXEL: n_pixels++;
            FUNC_CLEAR: n_clears++;
            FUNC_UNUSED: n_ignored++;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_BITS-1:0] px);
        send_word('{FUNC_PIXEL, px, 8'($urandom), 8'($urandom)});
    endtask

    task automatic send_read(input logic [PIX_BITS-1:0] row_lvl,
                             input logic [PIX_BITS-1:0] col_lvl);
        send_word('{FUNC_READ, 8'($urandom), row_lvl, col_lvl});
    endtask

    task automatic send_clear();
        send_word('{FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    task automatic send_unused();
        send_word('{FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    // Wait for every read-back, let in-flight words drain, sit out any clearing sweep
    // and then let the words queued behind it drain as well
    task automatic settle();
        drop_valid();
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        while (o_ready !== 1'b1) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == REG_DIRECTION) cur_dir = val[DIR_BITS-1:0];
        else if (idx == REG_LINE_WIDTH) cur_width = val[WID_BITS-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- output side ----------------

    initial begin : result_sink
        int stall;
        bit took;
        t_glcm_read seen;
        t_glcm_read want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = (o_valid === 1'b1) && (i_ready === 1'b1);
                seen = '{o_entry_count, o_pair_total};
                @(posedge i_clk);
            end while (!took);
            if (pending_reads.size() == 0) begin
                report_error($sformatf("read-back with none pending (count %0d, total %0d)",
                                       seen.entry_count, seen.pair_total));
            end else begin
                want = pending_reads.pop_front();
                n_reads++;
                if (seen.entry_count !== want.entry_count) begin
                    report_error($sformatf("entry_count expected %0d got %0d",
                                           want.entry_count, seen.entry_count));
                end
                if (seen.pair_total !== want.pair_total) begin
                    report_error($sformatf("pair_total expected %0d got %0d",
                                           want.pair_total, seen.pair_total));
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [PIX_BITS-1:0] extreme_level();
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    // Mostly a small palette so that reads hit populated entries
    function automatic logic [PIX_BITS-1:0] pick_level();
        if ($urandom_range(0, 9) < 7) return palette[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_width();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)  return CFG_DATA_BITS'($urandom_range(0, 1));
        if (roll < 70) return CFG_DATA_BITS'($urandom_range(2, 12));
        if (roll < 90) return CFG_DATA_BITS'($urandom_range(13, 64));
        if (roll < 97) return CFG_DATA_BITS'($urandom_range(65, 300));
        return CFG_DATA_BITS'($urandom_range(MAX_WIDTH + 1, 4095));
    endfunction

    // ---------------- tests ----------------

    // Empty table after reset, an ignored word, then pairs at the reset settings
    task automatic test_reset_state();
        send_read(8'h00, 8'h00);
        send_read(8'hFF, 8'hFF);
        send_unused();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_read(8'h00, 8'hFF);
        send_read(8'hFF, 8'hFF);
        send_read(8'hFF, 8'h00);
    endtask

    // Width above the maximum acts as the maximum; this row also fills the whole line store
    task automatic test_wide_row();
        settle();
        cfg_write(REG_DIRECTION, CFG_DATA_BITS'(DIR_0));
        cfg_write(REG_LINE_WIDTH, CFG_DATA_BITS'(4095));
        while (first_row) begin
            send_pixel(8'($urandom));
            if ($urandom_range(0, 49) == 0) send_read(8'($urandom), 8'($urandom));
        end
        repeat (2) send_pixel(8'($urandom));
        send_read(8'($urandom), 8'($urandom));
        settle();
        cfg_write(REG_DIRECTION, CFG_DATA_BITS'(DIR_90));
        repeat (3) send_pixel(8'($urandom));
        send_read(row_store[scan_col - 1], left_px);
    endtask

    // Widths below two act as two; the first write also cuts the current row short
    task automatic test_narrow_widths();
        settle();
        cfg_write(REG_DIRECTION, CFG_DATA_BITS'(DIR_0));
        cfg_write(REG_LINE_WIDTH, CFG_DATA_BITS'(0));
        repeat (6) send_pixel(extreme_level());
        send_read(8'h00, 8'hFF);
        send_read(8'hFF, 8'hFF);
        settle();
        cfg_write(REG_LINE_WIDTH, CFG_DATA_BITS'(1));
        cfg_write(REG_DIRECTION, CFG_DATA_BITS'(DIR_135));
        repeat (4) send_pixel(extreme_level());
        send_read(8'hFF, 8'h00);
        send_read(8'h00, 8'h00);
    endtask

    // Clear empties the table and restarts on a first row; then a 45 degree pair
    task automatic test_clear();
        send_pixel(8'h80);
        send_clear();
        send_read(8'hFF, 8'h80);
        settle();
        cfg_write(REG_LINE_WIDTH, CFG_DATA_BITS'(2));
        cfg_write(REG_DIRECTION, CFG_DATA_BITS'(DIR_45));
        send_pixel(8'h11);
        send_pixel(8'h22);
        send_pixel(8'h33);
        send_pixel(8'h44);
        send_read(8'h11, 8'h44);
        send_read(8'h22, 8'h33);
    endtask

    // Phases of random settings, each a pixel stream with reads and some noise
    task automatic test_random_phases();
        int sent;
        int n;
        int roll;
        int clears_left;
        sent = 0;
        clears_left = 4;
        while (sent < RANDOM_ITEMS) begin
            settle();
            n_phases++;
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (clears_left > 0 && $urandom_range(0, 3) == 0) begin
                send_clear();
                clears_left--;
                sent++;
                settle();
            end
            // upper data bits are junk for the direction register
            cfg_write(REG_DIRECTION, CFG_DATA_BITS'($urandom));
            if ($urandom_range(0, 3) != 0) cfg_write(REG_LINE_WIDTH, pick_width());
            foreach (palette[k]) begin
                palette[k] = ($urandom_range(0, 4) == 0) ? extreme_level() : 8'($urandom);
            end
            n = $urandom_range(60, 160);
            repeat (n) begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    send_pixel(pick_level());
                    sent++;
                end else if (roll < 97) begin
                    send_read(pick_level(), pick_level());
                    sent++;
                end else if (roll < 99 || clears_left == 0) begin
                    send_unused();
                end else begin
                    send_clear();
                    clears_left--;
                    sent++;
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // ---------------- sequence ----------------

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_func      <= FUNC_PIXEL;
        i_pixel     <= '0;
        i_ref_level <= '0;
        i_nbr_level <= '0;
        i_ready     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_DIRECTION;
        i_cfg_data  <= '0;
        n_errors  = 0;
        n_pixels  = 0;
        n_reads   = 0;
        n_clears  = 0;
        n_ignored = 0;
        n_phases  = 0;
        vld_held  = 1'b0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        foreach (row_store[k]) row_store[k] = '0;
        foreach (palette[k]) palette[k] = '0;
        restart_image();
        cur_dir   = DIR_0;
        cur_width = LINE_WIDTH_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_wide_row();
        test_narrow_widths();
        test_clear();
        test_random_phases();

        settle();
        if (pending_reads.size() != 0) begin
            report_error($sformatf("%0d read-backs never arrived", pending_reads.size()));
        end
        $display("run: %0d pixels, %0d read-backs checked, %0d clears, %0d ignored words",
                 n_pixels, n_reads, n_clears, n_ignored);
        $display("     %0d random phases over all directions, widths 0 to 4095, %0d errors",
                 n_phases, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
src/glcm_pkg.sv
src/glcm_front.sv
src/glcm_queue.sv
src/glcm_back.sv
src/glcm_cooccurrence_accumulator.sv
verif/glcm_cooccurrence_accumulator_test.sv
